// ===== sv/pfde_pkg.sv =====
// ----------------------------------------------------------------------------
// pfde_pkg
// Types, constants and square lookup helpers for the Playfair digraph encryptor.
// ----------------------------------------------------------------------------
package pfde_pkg;

    localparam int SQ_DIM   = 5;
    localparam int IDX_W    = $clog2(SQ_DIM);
    localparam int CHAR_W   = 8;
    localparam int ROW_W    = SQ_DIM * CHAR_W;
    localparam int APB_DW   = 64;
    localparam int APB_AW   = 6;

    localparam logic [IDX_W-1:0]  SQ_LAST    = IDX_W'(SQ_DIM - 1);
    localparam logic [CHAR_W-1:0] SPACE_CODE = 8'd32;
    localparam logic [CHAR_W-1:0] PAD_RESET  = 8'd122;

    // register indexes (paddr[5:3])
    localparam logic [2:0] REG_ROW_A = 3'd0;
    localparam logic [2:0] REG_ROW_B = 3'd1;
    localparam logic [2:0] REG_ROW_C = 3'd2;
    localparam logic [2:0] REG_ROW_D = 3'd3;
    localparam logic [2:0] REG_ROW_E = 3'd4;
    localparam logic [2:0] REG_PAD   = 3'd5;

    typedef logic [CHAR_W-1:0] char_t;
    typedef char_t [SQ_DIM-1:0][SQ_DIM-1:0] square_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } loc_t;

    // last match in row-major order wins
    function automatic loc_t locate(square_t sq, char_t ch);
        loc_t loc;
        loc = '0;
        for (int r = 0; r < SQ_DIM; r++)
        begin
            for (int c = 0; c < SQ_DIM; c++)
            begin
                if (sq[r][c] == ch)
                begin
                    loc.found = 1'b1;
                    loc.row   = IDX_W'(r);
                    loc.col   = IDX_W'(c);
                end
            end
        end
        return loc;
    endfunction

    function automatic logic [IDX_W-1:0] next_idx(logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] nxt;
        nxt = (idx == SQ_LAST) ? '0 : idx + 1'b1;
        return nxt;
    endfunction

endpackage

// ===== sv/playfair_digraph_encrypt.sv =====
// ----------------------------------------------------------------------------
// playfair_digraph_encrypt
// Pairs non-space text bytes and encrypts each pair against a 5x5 key square.
// ----------------------------------------------------------------------------
// Path: a pair's first result is presented from the result register after the
// byte that completes it has passed the input register.
// Throughput: one byte accepted per cycle unless stalled behind a busy result
// register; each pair holds the output port until both of its results are taken.
// Reset: asynchronous, clears held byte and pipeline; square rows 0, pad 'z'.
module playfair_digraph_encrypt
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] text_byte
    input  logic                          s_tlast,   // line_end

    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [7:0] cipher_byte
    output logic                          m_tlast,   // run_last
    output logic                          m_tuser,   // [0] key_miss

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pfde_pkg::APB_AW-1:0]   paddr,
    input  logic [pfde_pkg::APB_DW-1:0]   pwdata,
    output logic [pfde_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    logic [pfde_pkg::ROW_W-1:0]  rows_reg [pfde_pkg::SQ_DIM];
    pfde_pkg::char_t             pad_reg;

    logic                        in_valid_reg;
    logic                        in_valid_next;
    pfde_pkg::char_t             in_byte_reg;
    logic                        in_last_reg;

    logic                        held_valid_reg;
    logic                        held_valid_next;
    pfde_pkg::char_t             held_byte_reg;
    pfde_pkg::char_t             held_byte_next;

    logic                        pair_valid_reg;
    logic                        pair_valid_next;
    logic                        phase_reg;
    logic                        phase_next;
    pfde_pkg::char_t             x_reg;
    pfde_pkg::char_t             y_reg;
    logic                        miss_reg;

    pfde_pkg::square_t           square;
    pfde_pkg::loc_t              loc_a;
    pfde_pkg::loc_t              loc_b;
    pfde_pkg::char_t             first_ch;
    pfde_pkg::char_t             second_ch;
    pfde_pkg::char_t             x_ch;
    pfde_pkg::char_t             y_ch;
    logic                        miss;
    logic                        emit;
    logic                        is_space;
    logic                        res_free;
    logic                        consume;
    logic                        s_accept;
    logic                        m_accept;
    logic                        cfg_wr;
    logic [2:0]                  cfg_idx;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign cfg_idx  = paddr[5:3];

    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_tvalid && m_tready;

    always_comb
    begin
        for (int r = 0; r < pfde_pkg::SQ_DIM; r++)
        begin
            for (int c = 0; c < pfde_pkg::SQ_DIM; c++)
            begin
                square[r][c] = rows_reg[r][c*pfde_pkg::CHAR_W +: pfde_pkg::CHAR_W];
            end
        end
    end

    always_comb
    begin
        case (cfg_idx)
            pfde_pkg::REG_ROW_A: prdata = pfde_pkg::APB_DW'(rows_reg[0]);
            pfde_pkg::REG_ROW_B: prdata = pfde_pkg::APB_DW'(rows_reg[1]);
            pfde_pkg::REG_ROW_C: prdata = pfde_pkg::APB_DW'(rows_reg[2]);
            pfde_pkg::REG_ROW_D: prdata = pfde_pkg::APB_DW'(rows_reg[3]);
            pfde_pkg::REG_ROW_E: prdata = pfde_pkg::APB_DW'(rows_reg[4]);
            pfde_pkg::REG_PAD:   prdata = pfde_pkg::APB_DW'(pad_reg);
            default:             prdata = '0;
        endcase
    end

    // pairing decision
    always_comb
    begin
        is_space        = (in_byte_reg == pfde_pkg::SPACE_CODE);
        emit            = 1'b0;
        first_ch        = in_byte_reg;
        second_ch       = pad_reg;
        held_valid_next = held_valid_reg;
        held_byte_next  = held_byte_reg;
        if (is_space)
        begin
            if (in_last_reg && held_valid_reg)
            begin
                emit            = 1'b1;
                first_ch        = held_byte_reg;
                held_valid_next = 1'b0;
            end
        end
        else if (held_valid_reg)
        begin
            emit            = 1'b1;
            first_ch        = held_byte_reg;
            second_ch       = in_byte_reg;
            held_valid_next = 1'b0;
        end
        else if (in_last_reg)
        begin
            emit = 1'b1;
        end
        else
        begin
            held_valid_next = 1'b1;
            held_byte_next  = in_byte_reg;
        end
    end

    // square lookup and digraph rules
    always_comb
    begin
        loc_a = pfde_pkg::locate(square, first_ch);
        loc_b = pfde_pkg::locate(square, second_ch);
        miss  = 1'b0;
        if (!loc_a.found || !loc_b.found)
        begin
            x_ch = first_ch;
            y_ch = second_ch;
            miss = 1'b1;
        end
        else if (loc_a.row == loc_b.row)
        begin
            x_ch = square[loc_a.row][pfde_pkg::next_idx(loc_a.col)];
            y_ch = square[loc_b.row][pfde_pkg::next_idx(loc_b.col)];
        end
        else if (loc_a.col == loc_b.col)
        begin
            x_ch = square[pfde_pkg::next_idx(loc_a.row)][loc_a.col];
            y_ch = square[pfde_pkg::next_idx(loc_b.row)][loc_b.col];
        end
        else
        begin
            x_ch = square[loc_a.row][loc_b.col];
            y_ch = square[loc_b.row][loc_a.col];
        end
    end

    // handshake
    assign res_free = !pair_valid_reg || (m_tready && phase_reg);
    assign consume  = in_valid_reg && (!emit || res_free);
    assign s_tready = !in_valid_reg || consume;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (consume)
        begin
            in_valid_next = 1'b0;
        end

        pair_valid_next = pair_valid_reg;
        phase_next      = phase_reg;
        if (consume && emit)
        begin
            pair_valid_next = 1'b1;
            phase_next      = 1'b0;
        end
        else if (m_accept)
        begin
            if (phase_reg)
            begin
                pair_valid_next = 1'b0;
                phase_next      = 1'b0;
            end
            else
            begin
                phase_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            held_valid_reg <= 1'b0;
            pair_valid_reg <= 1'b0;
            phase_reg      <= 1'b0;
            pad_reg        <= pfde_pkg::PAD_RESET;
            for (int i = 0; i < pfde_pkg::SQ_DIM; i++)
            begin
                rows_reg[i] <= '0;
            end
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            pair_valid_reg <= pair_valid_next;
            phase_reg      <= phase_next;
            if (consume)
            begin
                held_valid_reg <= held_valid_next;
            end
            if (cfg_wr)
            begin
                case (cfg_idx)
                    pfde_pkg::REG_ROW_A: rows_reg[0] <= pwdata[pfde_pkg::ROW_W-1:0];
                    pfde_pkg::REG_ROW_B: rows_reg[1] <= pwdata[pfde_pkg::ROW_W-1:0];
                    pfde_pkg::REG_ROW_C: rows_reg[2] <= pwdata[pfde_pkg::ROW_W-1:0];
                    pfde_pkg::REG_ROW_D: rows_reg[3] <= pwdata[pfde_pkg::ROW_W-1:0];
                    pfde_pkg::REG_ROW_E: rows_reg[4] <= pwdata[pfde_pkg::ROW_W-1:0];
                    pfde_pkg::REG_PAD:   pad_reg     <= pwdata[pfde_pkg::CHAR_W-1:0];
                    default:             ;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (consume)
        begin
            held_byte_reg <= held_byte_next;
        end
        if (consume && emit)
        begin
            x_reg    <= x_ch;
            y_reg    <= y_ch;
            miss_reg <= miss;
        end
    end

    assign m_tvalid = pair_valid_reg;
    assign m_tdata  = phase_reg ? y_reg : x_reg;
    assign m_tlast  = phase_reg;
    assign m_tuser  = miss_reg;

    // second result of a pair follows its first
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (m_accept && !m_tlast) |=> (m_tvalid && m_tlast))
        else $error("second result of pair missing");

    // miss flag is the same on both results of a pair
    a_miss_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (m_accept && !m_tlast) |=> $stable(m_tuser))
        else $error("key miss differs within pair");

    // input stage only stalls behind a busy result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !consume) |-> (pair_valid_reg && emit))
        else $error("input stage stalled without cause");

    // nothing is held while a byte with line end has been consumed
    a_line_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && in_last_reg) |=> !held_valid_reg)
        else $error("byte still held after line end");

endmodule
